FILE: design/dept_pkg.sv
package dept_pkg;

    localparam int NODE_DEPTH_DEF = 65536;
    localparam int ALPHABET_DEF   = 26;
    localparam int TEXT_DEPTH_DEF = 65536;

    localparam int LETTER_W = 5;
    localparam int HIT_W    = 16;
    localparam int SDEP_W   = 16;
    localparam int TOTAL_W  = 31;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    localparam logic [1:0] CMD_BACK  = 2'd0;
    localparam logic [1:0] CMD_FRONT = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

endpackage

FILE: design/dept_ram.sv
module dept_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/double_ended_palindromic_tree_unit.sv
// Double-ended palindromic tree unit.
// Input channel s_valid/s_ready carries s_command and s_letter: push a letter
// at the back, push at the front, or clear text and tree. Every input
// transaction yields exactly one result transaction on m_valid/m_ready:
// node of the longest palindrome at the pushed end, its length, node count,
// new-node flag, its palindromic-suffix depth, its hit count, the running
// palindrome total and a full flag for a refused push.
// Text letters, per-node records and child rows sit in three single-port
// read, single-port write RAMs with a registered read.
// A push checks the end node (NCHK) and the text letter (TCHK), reads the
// child (CRD, CQ, VQ) and ends in DONE. Each suffix link followed passes NRD
// and NCHK, and TCHK too when the text letter is read and differs. A new
// node walks the suffix links once more before it is written. Report-only
// commands pass RQ and DONE; clear passes INIT0, INIT1 and DONE. m_valid
// rises with s_ready as DONE hands over. One transaction is worked at a time.
// After reset the two roots are written (INIT0, INIT1) while s_ready is low.
// The result waits in an output register; a new transaction is accepted
// while it waits, and its result is held until the receiver takes the
// previous one.
module double_ended_palindromic_tree_unit
    import dept_pkg::*;
#(
    parameter int NODE_DEPTH = NODE_DEPTH_DEF,
    parameter int ALPHABET   = ALPHABET_DEF,
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [4:0]  s_letter,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_node,
    output logic [15:0] m_pal_length,
    output logic [16:0] m_node_count,
    output logic        m_new_node,
    output logic [15:0] m_ending_count,
    output logic [15:0] m_node_hits,
    output logic [30:0] m_total_palindromes,
    output logic        m_full_res
);

    localparam int NW   = $clog2(NODE_DEPTH);
    localparam int CW   = $clog2(NODE_DEPTH + 1);
    localparam int TW   = $clog2(TEXT_DEPTH);
    localparam int LW   = $clog2(TEXT_DEPTH + 1);
    localparam int LENW = LW + 1;
    localparam int PW   = LW + 2;
    localparam int CDEP = NODE_DEPTH * ALPHABET;
    localparam int CAW  = $clog2(CDEP);
    localparam int CAP  = (TEXT_DEPTH < NODE_DEPTH - 2) ? TEXT_DEPTH : NODE_DEPTH - 2;

    // node word: {parent, letter, hits, depth, link, length}
    localparam int O_LEN = 0;
    localparam int O_LNK = LENW;
    localparam int O_DEP = O_LNK + NW;
    localparam int O_HIT = O_DEP + SDEP_W;
    localparam int O_LET = O_HIT + HIT_W;
    localparam int O_PAR = O_LET + LETTER_W;
    localparam int NODE_W = O_PAR + NW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT0 = 4'd1;
    localparam logic [3:0] S_INIT1 = 4'd2;
    localparam logic [3:0] S_NCHK  = 4'd3;
    localparam logic [3:0] S_TCHK  = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CQ    = 4'd6;
    localparam logic [3:0] S_VQ    = 4'd7;
    localparam logic [3:0] S_RQ    = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_NRD   = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [TW-1:0] head_reg, head_next;
    logic [LW-1:0] tlen_reg, tlen_next;
    logic [CW-1:0] used_reg, used_next;
    logic [NW-1:0] front_reg, front_next, back_reg, back_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic        clr_reg, clr_next;
    logic        fside_reg, fside_next;
    logic        phase_reg, phase_next;
    logic        cok_reg, cok_next;
    logic [LETTER_W-1:0] ch_reg, ch_next;
    logic [NW-1:0] cur_reg, cur_next, link_reg, link_next, last_link_reg, last_link_next;
    logic [NW-1:0] par_reg, par_next;
    logic [NW-1:0] cand_reg, cand_next;
    logic signed [LENW-1:0] len_reg, len_next, last_len_reg, last_len_next;
    logic [CAW-1:0] slot_reg, slot_next;

    logic [NW-1:0]     r_node_reg, r_node_next;
    logic [15:0]       r_len_reg, r_len_next;
    logic              r_new_reg, r_new_next, r_full_reg, r_full_next;
    logic [SDEP_W-1:0] r_dep_reg, r_dep_next;
    logic [HIT_W-1:0]  r_hit_reg, r_hit_next;

    logic        mv_reg;
    logic [15:0] o_node_reg, o_len_reg, o_dep_reg, o_hit_reg;
    logic [16:0] o_cnt_reg;
    logic        o_new_reg, o_full_reg;
    logic [30:0] o_tot_reg;

    logic              node_we;
    logic [NW-1:0]     node_waddr, node_raddr;
    logic [NODE_W-1:0] node_wdata, node_q;
    logic              ring_we;
    logic [TW-1:0]     ring_waddr, ring_raddr;
    logic [LETTER_W-1:0] ring_q;
    logic              child_we;
    logic [CAW-1:0]    child_raddr;
    logic [NW-1:0]     child_q;

    logic signed [LENW-1:0] q_len;
    logic [NW-1:0]     q_link, q_par;
    logic [SDEP_W-1:0] q_dep;
    logic [HIT_W-1:0]  q_hit, q_hit_inc;
    logic [LETTER_W-1:0] q_let;
    logic signed [PW-1:0] pos, size_s;
    logic              pos_ok;
    logic [TW:0]       rsum, wsum;
    logic [TW-1:0]     pos_addr, back_addr, head_dec;
    logic [CAW-1:0]    slot_cur;
    logic              accept, out_free, found;
    logic signed [LENW-1:0] new_len, tlen_s;
    logic [SDEP_W-1:0] new_dep;
    logic [NW-1:0]     new_lnk;

    dept_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_q)
    );

    dept_ram #(.WIDTH(LETTER_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
        .aclk(aclk), .we(ring_we), .waddr(ring_waddr), .wdata(ch_next),
        .raddr(ring_raddr), .rdata(ring_q)
    );

    dept_ram #(.WIDTH(NW), .DEPTH(CDEP)) u_child_ram (
        .aclk(aclk), .we(child_we), .waddr(slot_reg), .wdata(NW'(used_reg)),
        .raddr(child_raddr), .rdata(child_q)
    );

    assign q_len  = node_q[O_LNK-1:O_LEN];
    assign q_link = node_q[O_DEP-1:O_LNK];
    assign q_dep  = node_q[O_HIT-1:O_DEP];
    assign q_hit  = node_q[O_LET-1:O_HIT];
    assign q_let  = node_q[O_PAR-1:O_LET];
    assign q_par  = node_q[NODE_W-1:O_PAR];
    assign q_hit_inc = (q_hit == HIT_MAX) ? q_hit : q_hit + 1'b1;

    assign size_s = $signed({2'b00, tlen_reg});
    assign pos    = fside_reg ? PW'(q_len) + PW'(1) : size_s - PW'(q_len) - PW'(2);
    assign pos_ok = !pos[PW-1] && (pos < size_s);
    assign rsum   = {1'b0, head_reg} + (TW+1)'(pos);
    assign pos_addr = (rsum >= (TW+1)'(TEXT_DEPTH)) ? TW'(rsum - (TW+1)'(TEXT_DEPTH))
                                                    : TW'(rsum);
    assign wsum   = {1'b0, head_reg} + (TW+1)'(tlen_reg);
    assign back_addr = (wsum >= (TW+1)'(TEXT_DEPTH)) ? TW'(wsum - (TW+1)'(TEXT_DEPTH))
                                                     : TW'(wsum);
    assign head_dec = (head_reg == '0) ? TW'(TEXT_DEPTH - 1) : head_reg - 1'b1;
    assign slot_cur = CAW'(cur_reg) * CAW'(ALPHABET) + CAW'(ch_reg);
    assign ring_raddr  = pos_addr;
    assign child_raddr = slot_cur;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !mv_reg || m_ready;
    assign found    = cok_reg && (q_par == cur_reg) && (q_let == ch_reg);
    assign new_len  = last_len_reg + LENW'(2);
    assign tlen_s   = $signed({1'b0, tlen_reg});

    always_comb begin
        if (found) begin
            new_dep = q_dep + 1'b1;
            new_lnk = cand_reg;
        end else begin
            new_dep = SDEP_W'(1);
            new_lnk = '0;
        end
    end

    always_comb begin
        case (state_reg)
            S_IDLE:  node_raddr = (s_command == CMD_FRONT) ? front_reg : back_reg;
            S_CQ:    node_raddr = child_q;
            default: node_raddr = cur_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        head_next = head_reg;
        tlen_next = tlen_reg;
        used_next = used_reg;
        front_next = front_reg;
        back_next = back_reg;
        total_next = total_reg;
        clr_next = clr_reg;
        fside_next = fside_reg;
        phase_next = phase_reg;
        cok_next = cok_reg;
        ch_next = ch_reg;
        cur_next = cur_reg;
        link_next = link_reg;
        last_link_next = last_link_reg;
        par_next = par_reg;
        cand_next = cand_reg;
        len_next = len_reg;
        last_len_next = last_len_reg;
        slot_next = slot_reg;
        r_node_next = r_node_reg;
        r_len_next = r_len_reg;
        r_new_next = r_new_reg;
        r_full_next = r_full_reg;
        r_dep_next = r_dep_reg;
        r_hit_next = r_hit_reg;
        node_we = 1'b0;
        node_waddr = cand_reg;
        node_wdata = node_q;
        ring_we = 1'b0;
        ring_waddr = back_addr;
        child_we = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ch_next = s_letter;
                    fside_next = (s_command == CMD_FRONT);
                    phase_next = 1'b0;
                    r_new_next = 1'b0;
                    r_full_next = 1'b0;
                    if (s_command == CMD_CLEAR) begin
                        head_next = '0;
                        tlen_next = '0;
                        used_next = CW'(2);
                        front_next = '0;
                        back_next = '0;
                        total_next = '0;
                        clr_next = 1'b1;
                        r_node_next = '0;
                        r_len_next = '0;
                        r_dep_next = '0;
                        r_hit_next = '0;
                        state_next = S_INIT0;
                    end else if (s_command != CMD_BACK && s_command != CMD_FRONT) begin
                        r_node_next = back_reg;
                        state_next = S_RQ;
                    end else if (32'(s_letter) >= ALPHABET) begin
                        r_node_next = node_raddr;
                        state_next = S_RQ;
                    end else if (tlen_reg >= LW'(CAP)) begin
                        r_node_next = node_raddr;
                        r_full_next = 1'b1;
                        state_next = S_RQ;
                    end else begin
                        ring_we = 1'b1;
                        if (s_command == CMD_FRONT) begin
                            ring_waddr = head_dec;
                            head_next = head_dec;
                        end
                        tlen_next = tlen_reg + 1'b1;
                        cur_next = node_raddr;
                        state_next = S_NCHK;
                    end
                end
            end
            S_INIT0: begin
                node_we = 1'b1;
                node_waddr = '0;
                node_wdata = '0;
                node_wdata[O_DEP-1:O_LNK] = NW'(1);
                state_next = S_INIT1;
            end
            S_INIT1: begin
                node_we = 1'b1;
                node_waddr = NW'(1);
                node_wdata = '0;
                node_wdata[O_LNK-1:O_LEN] = '1;
                node_wdata[O_DEP-1:O_LNK] = NW'(1);
                state_next = clr_reg ? S_DONE : S_IDLE;
            end
            S_NRD: begin
                state_next = S_NCHK;
            end
            S_NCHK: begin
                len_next = q_len;
                link_next = q_link;
                if (pos_ok) begin
                    state_next = S_TCHK;
                end else begin
                    cur_next = q_link;
                    state_next = S_NRD;
                end
            end
            S_TCHK: begin
                if (ring_q == ch_reg) begin
                    if (!phase_reg) begin
                        last_len_next = len_reg;
                        last_link_next = link_reg;
                        par_next = cur_reg;
                    end
                    state_next = S_CRD;
                end else begin
                    cur_next = link_reg;
                    state_next = S_NRD;
                end
            end
            S_CRD: begin
                if (!phase_reg) begin
                    slot_next = slot_cur;
                end
                state_next = S_CQ;
            end
            S_CQ: begin
                cand_next = child_q;
                cok_next = (CW'(child_q) >= CW'(2)) && (CW'(child_q) < used_reg);
                state_next = S_VQ;
            end
            S_VQ: begin
                if (!phase_reg) begin
                    if (found) begin
                        node_we = 1'b1;
                        node_waddr = cand_reg;
                        node_wdata = node_q;
                        node_wdata[O_LET-1:O_HIT] = q_hit_inc;
                        total_next = total_reg + TOTAL_W'(q_dep);
                        r_node_next = cand_reg;
                        r_len_next = 16'(q_len);
                        r_dep_next = q_dep;
                        r_hit_next = q_hit_inc;
                        if (fside_reg) begin
                            front_next = cand_reg;
                            if (q_len == tlen_s) back_next = cand_reg;
                        end else begin
                            back_next = cand_reg;
                            if (q_len == tlen_s) front_next = cand_reg;
                        end
                        state_next = S_DONE;
                    end else begin
                        phase_next = 1'b1;
                        cur_next = last_link_reg;
                        state_next = S_NRD;
                    end
                end else begin
                    node_we = 1'b1;
                    node_waddr = NW'(used_reg);
                    node_wdata = {par_reg, ch_reg, HIT_W'(1), new_dep, new_lnk, new_len};
                    child_we = 1'b1;
                    used_next = used_reg + 1'b1;
                    total_next = total_reg + TOTAL_W'(new_dep);
                    r_node_next = NW'(used_reg);
                    r_len_next = 16'(new_len);
                    r_dep_next = new_dep;
                    r_hit_next = HIT_W'(1);
                    r_new_next = 1'b1;
                    if (fside_reg) begin
                        front_next = NW'(used_reg);
                        if (new_len == tlen_s) back_next = NW'(used_reg);
                    end else begin
                        back_next = NW'(used_reg);
                        if (new_len == tlen_s) front_next = NW'(used_reg);
                    end
                    state_next = S_DONE;
                end
            end
            S_RQ: begin
                r_len_next = q_len[LENW-1] ? 16'd0 : 16'(q_len);
                r_dep_next = q_dep;
                r_hit_next = q_hit;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    clr_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT0;
            head_reg <= '0;
            tlen_reg <= '0;
            used_reg <= CW'(2);
            front_reg <= '0;
            back_reg <= '0;
            total_reg <= '0;
            clr_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg <= head_next;
            tlen_reg <= tlen_next;
            used_reg <= used_next;
            front_reg <= front_next;
            back_reg <= back_next;
            total_reg <= total_next;
            clr_reg <= clr_next;
            if (state_reg == S_DONE && out_free) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fside_reg <= fside_next;
        phase_reg <= phase_next;
        cok_reg <= cok_next;
        ch_reg <= ch_next;
        cur_reg <= cur_next;
        link_reg <= link_next;
        last_link_reg <= last_link_next;
        par_reg <= par_next;
        cand_reg <= cand_next;
        len_reg <= len_next;
        last_len_reg <= last_len_next;
        slot_reg <= slot_next;
        r_node_reg <= r_node_next;
        r_len_reg <= r_len_next;
        r_new_reg <= r_new_next;
        r_full_reg <= r_full_next;
        r_dep_reg <= r_dep_next;
        r_hit_reg <= r_hit_next;
        if (state_reg == S_DONE && out_free) begin
            o_node_reg <= 16'(r_node_reg);
            o_len_reg <= r_len_reg;
            o_cnt_reg <= 17'(used_reg);
            o_new_reg <= r_new_reg;
            o_dep_reg <= 16'(r_dep_reg);
            o_hit_reg <= 16'(r_hit_reg);
            o_tot_reg <= 31'(total_reg);
            o_full_reg <= r_full_reg;
        end
    end

    assign m_valid = mv_reg;
    assign m_node = o_node_reg;
    assign m_pal_length = o_len_reg;
    assign m_node_count = o_cnt_reg;
    assign m_new_node = o_new_reg;
    assign m_ending_count = o_dep_reg;
    assign m_node_hits = o_hit_reg;
    assign m_total_palindromes = o_tot_reg;
    assign m_full_res = o_full_reg;

endmodule

FILE: bench/double_ended_palindromic_tree_checker.sv
`timescale 1ns / 100ps
module double_ended_palindromic_tree_checker
    import dept_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [4:0]  s_letter,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_node,
    input  logic [15:0] m_pal_length,
    input  logic [16:0] m_node_count,
    input  logic        m_new_node,
    input  logic [15:0] m_ending_count,
    input  logic [15:0] m_node_hits,
    input  logic [30:0] m_total_palindromes,
    input  logic        m_full_res,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          nodes_made_seen,
    output int          full_seen
);

    localparam int NDEP = NODE_DEPTH_DEF;
    localparam int TDEP = TEXT_DEPTH_DEF;
    localparam int ALPH = ALPHABET_DEF;
    localparam int CAP  = (TDEP < NDEP - 2) ? TDEP : NDEP - 2;

    typedef struct packed {
        logic [15:0] node;
        logic [15:0] pal_length;
        logic [16:0] node_count;
        logic        new_node;
        logic [15:0] ending_count;
        logic [15:0] node_hits;
        logic [30:0] total;
        logic        full;
    } tree_result_t;

    tree_result_t expected_results[$];

    logic [4:0]  letters [TDEP];
    int          pal_len [NDEP];
    int unsigned link_of [NDEP];
    int unsigned depth_of[NDEP];
    int unsigned hits_of [NDEP];
    int unsigned child_of[int unsigned];
    int unsigned head_pos, text_len, used, front_nd, back_nd;
    logic [31:0] sum_total;

    function automatic int unsigned make_node(int len);
        int unsigned nd;
        nd = used;
        used++;
        pal_len[nd]  = len;
        link_of[nd]  = 0;
        depth_of[nd] = 0;
        hits_of[nd]  = 0;
        for (int c = 0; c < ALPH; c++) child_of.delete(nd * ALPH + c);
        return nd;
    endfunction

    function automatic void clear_tree();
        int unsigned dummy;
        head_pos  = 0;
        text_len  = 0;
        used      = 0;
        sum_total = 0;
        child_of.delete();
        dummy = make_node(0);
        dummy = make_node(-1);
        link_of[0] = 1;
        link_of[1] = 1;
        front_nd = 0;
        back_nd  = 0;
    endfunction

    function automatic bit matches_end(int unsigned nd, int unsigned ch, bit front);
        longint p;
        p = front ? longint'(pal_len[nd]) + 1 : longint'(text_len) - pal_len[nd] - 2;
        if (p < 0 || p >= text_len) return 0;
        return letters[(head_pos + p) % TDEP] == ch;
    endfunction

    function automatic int unsigned climb(int unsigned nd, int unsigned ch, bit front);
        int unsigned guard;
        guard = 0;
        while (!matches_end(nd, ch, front) && guard < NDEP + 2) begin
            nd = link_of[nd] % NDEP;
            guard++;
        end
        return nd;
    endfunction

    function automatic int unsigned child_at(int unsigned nd, int unsigned ch);
        return child_of.exists(nd * ALPH + ch) ? child_of[nd * ALPH + ch] : 0;
    endfunction

    function automatic int unsigned extend(int unsigned ch, int unsigned last,
                                           bit front, output bit made);
        int unsigned from, nd, lk;
        last = climb(last, ch, front);
        made = 0;
        if (child_at(last, ch) == 0) begin
            from = climb(link_of[last], ch, front);
            nd = make_node(pal_len[last] + 2);
            lk = child_at(from, ch);
            link_of[nd]  = lk;
            depth_of[nd] = depth_of[lk] + 1;
            child_of[last * ALPH + ch] = nd;
            made = 1;
        end
        last = child_at(last, ch);
        sum_total += depth_of[last];
        if (hits_of[last] < HIT_MAX) hits_of[last]++;
        return last;
    endfunction

    function automatic tree_result_t describe(int unsigned nd, bit made, bit full);
        tree_result_t r;
        r.node         = nd[15:0];
        r.pal_length   = pal_len[nd] < 0 ? 16'd0 : pal_len[nd][15:0];
        r.node_count   = used[16:0];
        r.new_node     = made;
        r.ending_count = depth_of[nd][15:0];
        r.node_hits    = hits_of[nd][15:0];
        r.total        = sum_total[30:0];
        r.full         = full;
        return r;
    endfunction

    function automatic tree_result_t predict_tree(logic [1:0] cmd, logic [4:0] ch);
        bit front, made;
        front = (cmd == CMD_FRONT);
        made  = 0;
        if (cmd == CMD_CLEAR) begin
            clear_tree();
            return describe(back_nd, 0, 0);
        end
        if (cmd != CMD_BACK && cmd != CMD_FRONT) return describe(back_nd, 0, 0);
        if (ch >= ALPH) return describe(front ? front_nd : back_nd, 0, 0);
        if (text_len >= CAP) return describe(front ? front_nd : back_nd, 0, 1);
        if (front) begin
            head_pos = (head_pos + TDEP - 1) % TDEP;
            letters[head_pos] = ch;
            text_len++;
            front_nd = extend(ch, front_nd, 1, made);
            if (pal_len[front_nd] == text_len) back_nd = front_nd;
            return describe(front_nd, made, 0);
        end
        letters[(head_pos + text_len) % TDEP] = ch;
        text_len++;
        back_nd = extend(ch, back_nd, 0, made);
        if (pal_len[back_nd] == text_len) front_nd = back_nd;
        return describe(back_nd, made, 0);
    endfunction

    initial clear_tree();

    always @(posedge aclk) begin
        tree_result_t want, got;
        if (!aresetn) begin
            fail_count      <= 0;
            results_seen    <= 0;
            nodes_made_seen <= 0;
            full_seen       <= 0;
            pending         <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                                        predict_tree(s_command, s_letter));
            if (m_valid && m_ready) begin
                got = '{m_node, m_pal_length, m_node_count, m_new_node, m_ending_count,
                        m_node_hits, m_total_palindromes, m_full_res};
                results_seen    <= results_seen + 1;
                nodes_made_seen <= nodes_made_seen + m_new_node;
                full_seen       <= full_seen + m_full_res;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== got) begin
                        if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

FILE: bench/double_ended_palindromic_tree_unit_test.sv
`timescale 1ns / 100ps
module double_ended_palindromic_tree_unit_test;
    import dept_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_BACK;
    logic [4:0]  s_letter = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_node, m_pal_length, m_ending_count, m_node_hits;
    logic [16:0] m_node_count;
    logic        m_new_node, m_full_res;
    logic [30:0] m_total_palindromes;
    int          fail_count, pending, results_seen, nodes_made_seen, full_seen;
    int          send_idle = 0, recv_idle = 0;
    int          quiet_cycles = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    double_ended_palindromic_tree_unit u_top (.*);

    double_ended_palindromic_tree_checker u_checker (.*);

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 100000) begin
                $display("Regression FAIL");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [4:0] ch);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid   <= 1;
        s_command <= cmd;
        s_letter  <= ch;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0 || s_valid) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        int pal_len;
        logic [4:0] word[$];
        for (int i = 0; i < count; i++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 2) send_item(CMD_CLEAR, 5'($urandom));
            else if (pick < 4) send_item(2'($urandom), 5'($urandom));
            else if (pick < 30) begin
                pal_len = $urandom_range(1, 6);
                word.delete();
                for (int k = 0; k < pal_len; k++)
                    word.insert(word.size(), 5'($urandom_range(1)));
                for (int k = 0; k < pal_len; k++)
                    send_item($urandom_range(1) ? CMD_FRONT : CMD_BACK, word[k]);
                i += pal_len - 1;
            end else
                send_item($urandom_range(1) ? CMD_FRONT : CMD_BACK,
                          5'($urandom_range(3) == 0 ? $urandom_range(25)
                                                    : $urandom_range(2)));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        recv_idle = 30;
        send_item(CMD_BACK, 0);
        send_item(CMD_BACK, 25);
        send_item(CMD_BACK, 0);
        send_item(CMD_FRONT, 25);
        send_item(CMD_FRONT, 0);
        send_item(CMD_BACK, 31);
        send_item(CMD_FRONT, 26);
        send_item(2'd3, 5'd10);
        send_item(CMD_BACK, 0);
        send_item(CMD_BACK, 0);
        send_item(CMD_FRONT, 0);
        send_item(CMD_FRONT, 0);
        send_item(CMD_CLEAR, 5'd31);
        send_item(CMD_FRONT, 3);
        send_item(CMD_FRONT, 4);
        send_item(CMD_BACK, 3);
        send_item(CMD_BACK, 1);
        send_item(CMD_CLEAR, 0);
        drain();

        send_idle = 14; recv_idle = 68;
        random_phase(550);
        drain();
        send_idle = 68; recv_idle = 14;
        random_phase(550);
        send_idle = 0; recv_idle = 0;
        random_phase(550);
        drain();
        repeat (40) @(posedge aclk);

        $display("Covered %0d results, %0d new nodes, %0d refused pushes.",
                 results_seen, nodes_made_seen, full_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
